// File: design/acpd_pkg.sv
package acpd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 12;
    localparam int MEAN_W      = 12;
    localparam int GAIN_W      = 24;
    localparam int READING_W   = 20;
    localparam int PROD_W      = MEAN_W + GAIN_W;
    localparam int READ_SHIFT  = 16;
    localparam int BIT_CNT_W   = $clog2(MEAN_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = GAIN_W;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOLTS_GAIN   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD = 1'b1;

    // Result kinds
    localparam logic KIND_CALIBRATION = 1'b0;
    localparam logic KIND_MEASUREMENT = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul;
        logic finish;
    } acpd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_busy;
    } acpd_status_t;

endpackage

// File: design/acpd_if.sv
interface acpd_in_if;
    logic                          valid;
    logic                          ready;
    logic [acpd_pkg::SAMPLE_W-1:0] sample;
    logic                          period_end;

    modport source (output valid, output sample, output period_end, input ready);
    modport sink   (input valid, input sample, input period_end, output ready);
endinterface

interface acpd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [acpd_pkg::MEAN_W-1:0]    window_mean;
    logic [acpd_pkg::READING_W-1:0] reading;
    logic                           light_on;
    logic                           changed;

    modport source (output valid, output kind, output window_mean, output reading,
                    output light_on, output changed, input ready);
    modport sink   (input valid, input kind, input window_mean, input reading,
                    input light_on, input changed, output ready);
endinterface

// File: design/ac_presence_mean_abs_detector.sv
// A plain sample is taken at once while the block is idle; a closing sample passes through
// the divider steps, the gain multiply and the output load before its result shows.
// The block takes one sample per cycle inside a period; after a closing sample the input stalls
// through the divide, multiply and load, longer while an earlier result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears configuration, zero point, sums,
// load state and the output valid; the first period after reset is the calibration.
module ac_presence_mean_abs_detector #(
    parameter int MAX_PERIOD_SAMPLES = 65535,
    parameter int ADC_BITS           = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    acpd_in_if.sink                              in_ch,
    acpd_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [acpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [acpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    acpd_pkg::acpd_cmd_t    cmd;
    acpd_pkg::acpd_status_t status;

    // Sequence the period close
    acpd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_period_end (in_ch.period_end),
        .in_ready      (in_ch.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // Accumulate, divide, scale and hold the result
    acpd_dpath #(
        .MAX_PERIOD_SAMPLES (MAX_PERIOD_SAMPLES),
        .ADC_BITS           (ADC_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_sample       (in_ch.sample),
        .in_period_end   (in_ch.period_end),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_kind        (out_ch.kind),
        .out_window_mean (out_ch.window_mean),
        .out_reading     (out_ch.reading),
        .out_light_on    (out_ch.light_on),
        .out_changed     (out_ch.changed)
    );

endmodule

// File: design/acpd_ctrl.sv
module acpd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_period_end,
    output logic                   in_ready,
    input  acpd_pkg::acpd_status_t status,
    output acpd_pkg::acpd_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take samples while idle, and sequence one period close: divide, scale, deliver
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_period_end)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/acpd_dpath.sv
module acpd_dpath #(
    parameter int MAX_PERIOD_SAMPLES = 65535,
    parameter int ADC_BITS           = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  acpd_pkg::acpd_cmd_t                   cmd,
    output acpd_pkg::acpd_status_t                status,
    input  logic [acpd_pkg::SAMPLE_W-1:0]         in_sample,
    input  logic                                  in_period_end,
    input  logic                                  cfg_we,
    input  logic [acpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [acpd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  out_kind,
    output logic [acpd_pkg::MEAN_W-1:0]           out_window_mean,
    output logic [acpd_pkg::READING_W-1:0]        out_reading,
    output logic                                  out_light_on,
    output logic                                  out_changed
);

    localparam int SW      = acpd_pkg::SAMPLE_W;
    localparam int MW      = acpd_pkg::MEAN_W;
    localparam int TALLY_W = $clog2(MAX_PERIOD_SAMPLES + 1);
    localparam int SUM_W   = SW + TALLY_W;
    localparam logic [SW-1:0] SAMPLE_MASK =
        (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((32'd1 << ADC_BITS) - 32'd1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_PERIOD_SAMPLES);

    // Configuration
    logic [acpd_pkg::GAIN_W-1:0]    gain_reg;
    logic [acpd_pkg::READING_W-1:0] thr_reg;

    // Long-lived state
    logic          zero_known_reg;
    logic [SW-1:0] zero_level_reg;
    logic          load_on_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [TALLY_W-1:0] tally_reg;

    // Divider and multiplier
    logic [SUM_W-1:0]               rem_reg;
    logic [SUM_W-1:0]               dvs_reg;
    logic [MW-1:0]                  quo_reg;
    logic                           tally_zero_reg;
    logic [acpd_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [acpd_pkg::PROD_W-1:0]    prod_reg;

    // Output register
    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [MW-1:0]                  out_mean_reg;
    logic [acpd_pkg::READING_W-1:0] out_reading_reg;
    logic                           out_light_reg;
    logic                           out_changed_reg;

    logic [SW-1:0]      s_masked;
    logic [SW-1:0]      dev;
    logic               tally_sat;
    logic [SUM_W-1:0]   sum_add;
    logic [TALLY_W-1:0] tally_add;
    logic               rem_ge;
    logic [acpd_pkg::READING_W-1:0] reading;
    logic               now_on;
    logic [MW-1:0]      mean_masked;

    // Deviation of the incoming sample and saturating accumulation
    always_comb
    begin
        s_masked = in_sample & SAMPLE_MASK;
        if (!zero_known_reg)
        begin
            dev = s_masked;
        end
        else if (s_masked >= zero_level_reg)
        begin
            dev = s_masked - zero_level_reg;
        end
        else
        begin
            dev = zero_level_reg - s_masked;
        end
        tally_sat = (tally_reg == TALLY_MAX);
        sum_add   = tally_sat ? sum_reg : sum_reg + SUM_W'(dev);
        tally_add = tally_sat ? tally_reg : tally_reg + TALLY_W'(1);
    end

    assign rem_ge      = (rem_reg >= dvs_reg) && !tally_zero_reg;
    assign reading     = prod_reg[acpd_pkg::PROD_W-1:acpd_pkg::READ_SHIFT];
    assign now_on      = reading > thr_reg;
    assign mean_masked = quo_reg & SAMPLE_MASK;

    assign status.div_last = (bit_cnt_reg == '0);
    assign status.out_busy = out_valid_reg && !out_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            thr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acpd_pkg::REG_VOLTS_GAIN:   gain_reg <= cfg_data;
                acpd_pkg::REG_ON_THRESHOLD: thr_reg  <= cfg_data[acpd_pkg::READING_W-1:0];
                default:                    gain_reg <= gain_reg;
            endcase
        end
    end

    // Accumulate, and hand a closed period to the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            tally_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (in_period_end)
            begin
                sum_reg   <= '0;
                tally_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_add;
                tally_reg <= tally_add;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle, then the gain multiply
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_period_end)
        begin
            rem_reg        <= sum_add;
            dvs_reg        <= SUM_W'({tally_add, {(MW-1){1'b0}}});
            quo_reg        <= '0;
            tally_zero_reg <= (tally_add == '0);
            bit_cnt_reg    <= acpd_pkg::BIT_CNT_W'(MW - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quo_reg     <= {quo_reg[MW-2:0], rem_ge};
            dvs_reg     <= dvs_reg >> 1;
            bit_cnt_reg <= bit_cnt_reg - acpd_pkg::BIT_CNT_W'(1);
        end
        if (cmd.mul)
        begin
            prod_reg <= acpd_pkg::PROD_W'(quo_reg) * acpd_pkg::PROD_W'(gain_reg);
        end
    end

    // Zero point and load state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_known_reg <= 1'b0;
            zero_level_reg <= '0;
            load_on_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (!zero_known_reg)
            begin
                zero_known_reg <= 1'b1;
                zero_level_reg <= mean_masked;
            end
            else
            begin
                load_on_reg <= now_on;
            end
        end
    end

    // Output valid: set on finish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (!zero_known_reg)
            begin
                out_kind_reg    <= acpd_pkg::KIND_CALIBRATION;
                out_mean_reg    <= mean_masked;
                out_reading_reg <= '0;
                out_light_reg   <= load_on_reg;
                out_changed_reg <= 1'b0;
            end
            else
            begin
                out_kind_reg    <= acpd_pkg::KIND_MEASUREMENT;
                out_mean_reg    <= quo_reg;
                out_reading_reg <= reading;
                out_light_reg   <= now_on;
                out_changed_reg <= now_on != load_on_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_window_mean = out_mean_reg;
    assign out_reading     = out_reading_reg;
    assign out_light_on    = out_light_reg;
    assign out_changed     = out_changed_reg;

endmodule

// File: verif/ac_presence_mean_abs_detector_tb.sv
module ac_presence_mean_abs_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_SAMPLES    = 65535;
    localparam int  SETTLE_CYCLES  = 20;
    localparam int  STALL_LIMIT    = 5000;
    localparam int  LONG_HOLD      = 600;
    localparam int  ITEMS_PER_MODE = 460;
    localparam logic [acpd_pkg::READING_W-1:0] READING_TOP = '1;

    typedef struct packed {
        logic                           kind;
        logic [acpd_pkg::MEAN_W-1:0]    window_mean;
        logic [acpd_pkg::READING_W-1:0] reading;
        logic                           light_on;
        logic                           changed;
    } period_report_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_op_t;

    typedef struct {
        row_op_t                          op;
        logic [acpd_pkg::CFG_INDEX_W-1:0] index;
        logic [acpd_pkg::CFG_DATA_W-1:0]  data;
        logic [acpd_pkg::SAMPLE_W-1:0]    sample;
        logic                             last;
        int                               count;
        bit                               typed;
        period_report_t                   report;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                             cfg_we;
    logic [acpd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [acpd_pkg::CFG_DATA_W-1:0]  cfg_data;

    acpd_in_if  in_ch ();
    acpd_out_if out_ch ();

    ac_presence_mean_abs_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Detector shadow state
    bit                             meter_zero_known;
    logic [acpd_pkg::SAMPLE_W-1:0]  meter_zero;
    longint unsigned                meter_sum;
    int unsigned                    meter_tally;
    logic                           meter_load_on;
    logic [acpd_pkg::GAIN_W-1:0]    meter_gain;
    logic [acpd_pkg::READING_W-1:0] meter_threshold;

    period_report_t pending_reports[$];
    stim_row_t      directed_rows[$];
    int             mismatch_count;
    int             idle_pct;
    int             stall_pct;
    int             hold_asked;
    int             hold_served;
    int             hold_left;
    int             quiet_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the shadow detector by one accepted sample
    task automatic meter_sample(input logic [acpd_pkg::SAMPLE_W-1:0] s, input logic last);
        int unsigned     dev;
        longint unsigned mean;
        longint unsigned scaled;
        logic [acpd_pkg::READING_W-1:0] rd;
        logic            now_on;
        period_report_t  rep;
        if (meter_tally < MAX_SAMPLES)
        begin
            if (!meter_zero_known)
                dev = s;
            else
                dev = (s >= meter_zero) ? s - meter_zero : meter_zero - s;
            meter_sum   += dev;
            meter_tally += 1;
        end
        if (last)
        begin
            mean        = (meter_tally == 0) ? 0 : meter_sum / meter_tally;
            meter_sum   = 0;
            meter_tally = 0;
            if (!meter_zero_known)
            begin
                meter_zero       = mean[acpd_pkg::SAMPLE_W-1:0];
                meter_zero_known = 1'b1;
                rep = '{kind: acpd_pkg::KIND_CALIBRATION,
                        window_mean: mean[acpd_pkg::MEAN_W-1:0],
                        reading: '0, light_on: meter_load_on, changed: 1'b0};
            end
            else
            begin
                scaled = (mean * meter_gain) >> acpd_pkg::READ_SHIFT;
                rd     = (scaled > READING_TOP) ? READING_TOP
                                                : scaled[acpd_pkg::READING_W-1:0];
                now_on = rd > meter_threshold;
                rep = '{kind: acpd_pkg::KIND_MEASUREMENT,
                        window_mean: mean[acpd_pkg::MEAN_W-1:0],
                        reading: rd, light_on: now_on, changed: now_on != meter_load_on};
                meter_load_on = now_on;
            end
            pending_reports.push_back(rep);
        end
    endtask

    task automatic flag_mismatch(input string what, input period_report_t got,
                                 input period_report_t want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Offer one sample, hold it until the transaction completes
    task automatic send_sample(input logic [acpd_pkg::SAMPLE_W-1:0] s, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= s;
        in_ch.period_end <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        meter_sample(s, last);
        @(negedge clk);
    endtask

    // Drop valid and wait for every pending report to drain
    task automatic settle_outputs();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [acpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [acpd_pkg::CFG_DATA_W-1:0] value);
        settle_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == acpd_pkg::REG_VOLTS_GAIN)
            meter_gain = value;
        else
            meter_threshold = value[acpd_pkg::READING_W-1:0];
        @(negedge clk);
    endtask

    function automatic stim_row_t reg_row(input logic [acpd_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [acpd_pkg::CFG_DATA_W-1:0] value);
        stim_row_t r;
        r = '{op: ROW_WRITE, index: idx, data: value, sample: '0, last: 1'b0,
              count: 0, typed: 1'b0, report: '0};
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic [acpd_pkg::SAMPLE_W-1:0] s,
                                             input logic last, input int count);
        stim_row_t r;
        r = '{op: ROW_SAMPLE, index: '0, data: '0, sample: s, last: last,
              count: count, typed: 1'b0, report: '0};
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [acpd_pkg::SAMPLE_W-1:0] s,
                                            input period_report_t rep);
        stim_row_t r;
        r = sample_row(s, 1'b1, 1);
        r.typed  = 1'b1;
        r.report = rep;
        return r;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served  = hold_asked;
            hold_left    = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each result transaction and watch for a stuck block
    always @(posedge clk)
    begin
        period_report_t got;
        period_report_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{kind: out_ch.kind, window_mean: out_ch.window_mean,
                        reading: out_ch.reading, light_on: out_ch.light_on,
                        changed: out_ch.changed};
                if (pending_reports.size() == 0)
                    flag_mismatch("result with nothing pending", got, '0);
                else
                begin
                    want = pending_reports.pop_front();
                    if (got !== want)
                        flag_mismatch("period report", got, want);
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ac_presence_mean_abs_detector_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        int          sent;
        int          periods;
        int          len;
        int          amp;
        int          v;
        int          thr_mean;
        logic [acpd_pkg::CFG_DATA_W-1:0] gain;
        logic        last;
        int          mode_idle[4];
        int          mode_stall[4];

        mode_idle        = '{0, 84, 0, 37};
        mode_stall       = '{0, 0, 84, 37};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.sample     = '0;
        in_ch.period_end = 1'b0;
        out_ch.ready     = 1'b0;
        meter_zero_known = 1'b0;
        meter_zero       = '0;
        meter_sum        = 0;
        meter_tally      = 0;
        meter_load_on    = 1'b0;
        meter_gain       = '0;
        meter_threshold  = '0;
        mismatch_count   = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        hold_asked       = 0;
        hold_served      = 0;
        hold_left        = 0;
        quiet_cycles     = 0;

        // Calibration over the full sample range, then zero gain
        directed_rows.push_back(sample_row(12'd0, 1'b0, 1));
        directed_rows.push_back(sample_row(12'd4095, 1'b0, 1));
        directed_rows.push_back(sample_row(12'd2048, 1'b0, 1));
        directed_rows.push_back(known_row(12'd2049,
            '{acpd_pkg::KIND_CALIBRATION, 12'd2048, 20'd0, 1'b0, 1'b0}));
        directed_rows.push_back(known_row(12'd2048,
            '{acpd_pkg::KIND_MEASUREMENT, 12'd0, 20'd0, 1'b0, 1'b0}));
        directed_rows.push_back(known_row(12'd4095,
            '{acpd_pkg::KIND_MEASUREMENT, 12'd2047, 20'd0, 1'b0, 1'b0}));
        // Largest gain, threshold at both ends and at the strict boundary
        directed_rows.push_back(reg_row(acpd_pkg::REG_VOLTS_GAIN, 24'hFFFFFF));
        directed_rows.push_back(sample_row(12'd4095, 1'b0, 1));
        directed_rows.push_back(sample_row(12'd0, 1'b1, 1));
        directed_rows.push_back(reg_row(acpd_pkg::REG_ON_THRESHOLD, 24'h0FFFFF));
        directed_rows.push_back(sample_row(12'd0, 1'b1, 1));
        directed_rows.push_back(reg_row(acpd_pkg::REG_ON_THRESHOLD, 24'd524286));
        directed_rows.push_back(sample_row(12'd0, 1'b1, 1));
        directed_rows.push_back(reg_row(acpd_pkg::REG_ON_THRESHOLD, 24'd524287));
        directed_rows.push_back(sample_row(12'd0, 1'b1, 1));
        // Unity gain, zero deviation stays off
        directed_rows.push_back(reg_row(acpd_pkg::REG_VOLTS_GAIN, 24'd65536));
        directed_rows.push_back(reg_row(acpd_pkg::REG_ON_THRESHOLD, 24'd100));
        directed_rows.push_back(known_row(12'd2048,
            '{acpd_pkg::KIND_MEASUREMENT, 12'd0, 20'd0, 1'b0, 1'b0}));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.op == ROW_WRITE)
                write_reg(row.index, row.data);
            else
            begin
                for (int k = 0; k < row.count; k++)
                    send_sample(row.sample, row.last);
                if (row.typed)
                    pending_reports[pending_reports.size() - 1] = row.report;
            end
        end

        // Random periods under each handshake mode
        for (int mode = 0; mode < 4; mode++)
        begin
            settle_outputs();
            idle_pct  = mode_idle[mode];
            stall_pct = mode_stall[mode];
            gain      = (mode == 3) ? 24'hFFFFFF : 24'($urandom_range(1, 24'hFFFFFF));
            thr_mean  = $urandom_range(20, 900);
            write_reg(acpd_pkg::REG_VOLTS_GAIN, gain);
            write_reg(acpd_pkg::REG_ON_THRESHOLD,
                      acpd_pkg::CFG_DATA_W'((longint'(thr_mean) * gain)
                                            >> acpd_pkg::READ_SHIFT));
            if (mode == 0)
                hold_asked++;
            sent    = 0;
            periods = 0;
            while (sent < ITEMS_PER_MODE)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
                amp = $urandom_range(0, 2047);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 8)
                        v = $urandom_range(0, 4095);
                    else if ($urandom_range(0, 1))
                        v = meter_zero + $urandom_range(0, amp);
                    else
                        v = int'(meter_zero) - int'($urandom_range(0, amp));
                    if (v < 0)
                        v = 0;
                    if (v > 4095)
                        v = 4095;
                    last = (k == len - 1);
                    send_sample(acpd_pkg::SAMPLE_W'(v), last);
                    sent++;
                end
                periods++;
                // Pause the sender until all reports are out
                if (mode == 1 && periods % 15 == 0)
                    settle_outputs();
            end
        end

        settle_outputs();
        if (mismatch_count == 0)
            $display("ac_presence_mean_abs_detector_tb: PASS");
        else
            $display("ac_presence_mean_abs_detector_tb: FAIL");
        $finish;
    end

endmodule
